### hw/rtl/lzsd_pkg.sv
`timescale 1ns / 1ps

package lzsd_pkg;

   localparam int WINDOW_SIZE_DEF = 4096;
   localparam int BYTE_W          = 8;
   localparam int LEN_W           = 24;
   localparam int CNT_W           = 5;
   localparam int POS_W           = 12;
   localparam logic [POS_W-1:0]  START_POS = 12'hfee;
   localparam logic [CNT_W-1:0]  MIN_MATCH = 5'd3;
   localparam logic [BYTE_W-1:0] FLAG_FILL = 8'hff;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } seq_state_type;

   typedef enum logic [1:0] {
      PH_FLAG   = 2'd0,
      PH_FIRST  = 2'd1,
      PH_SECOND = 2'd2
   } phase_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              done;
   } emit_type;

endpackage

### hw/rtl/lzsd_ram.sv
`timescale 1ns / 1ps

module lzsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/lzsd_seq.sv
`timescale 1ns / 1ps

module lzsd_seq #(
   parameter int WINDOW_SIZE = lzsd_pkg::WINDOW_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [lzsd_pkg::BYTE_W-1:0]  in_byte,
   input  logic [lzsd_pkg::LEN_W-1:0]   out_len,
   input  logic                         out_free,
   output lzsd_pkg::emit_type           emit
);

   import lzsd_pkg::*;

   localparam int AW = $clog2(WINDOW_SIZE);

   seq_state_type     state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [15:0]       flags_ff, flags_in;
   logic [BYTE_W-1:0] low_ff, low_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              lit_ff, lit_in;
   logic [AW-1:0]     src_ff, src_in;
   logic [AW-1:0]     wpos_ff, wpos_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  prod_ff, prod_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr;
   logic [BYTE_W-1:0] ram_wdata, ram_rdata;

   logic [LEN_W-1:0]  prod_inc;
   logic [BYTE_W-1:0] emit_data;
   logic              stop, last, accept;
   logic [15:0]       flags_next;

   lzsd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WINDOW_SIZE)
   ) u_window (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (src_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         phase_ff <= PH_FLAG;
         flags_ff <= '0;
         low_ff   <= '0;
         wpos_ff  <= AW'(START_POS);
         clr_ff   <= '0;
         prod_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         flags_ff <= flags_in;
         low_ff   <= low_in;
         wpos_ff  <= wpos_in;
         clr_ff   <= clr_in;
         prod_ff  <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      lit_ff  <= lit_in;
      src_ff  <= src_in;
      cnt_ff  <= cnt_in;
   end

   assign prod_inc   = prod_ff + LEN_W'(1);
   assign stop       = !(prod_inc < out_len);
   assign last       = lit_ff || (cnt_ff == CNT_W'(1)) || stop;
   assign emit_data  = lit_ff ? byte_ff : ram_rdata;
   assign flags_next = flags_ff >> 1;
   assign in_ready   = (state_ff == ST_IDLE);
   assign accept     = in_valid && in_ready;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      flags_in  = flags_ff;
      low_in    = low_ff;
      byte_in   = byte_ff;
      lit_in    = lit_ff;
      src_in    = src_ff;
      cnt_in    = cnt_ff;
      wpos_in   = wpos_ff;
      clr_in    = clr_ff;
      prod_in   = prod_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = wpos_ff;
      ram_wdata = emit_data;
      emit      = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (prod_ff < out_len)) begin
               case (phase_ff)
                  PH_FIRST: begin
                     if (flags_ff[0]) begin
                        lit_in   = 1'b1;
                        byte_in  = in_byte;
                        state_in = ST_EMIT;
                     end else begin
                        low_in   = in_byte;
                        phase_in = PH_SECOND;
                     end
                  end
                  PH_SECOND: begin
                     lit_in   = 1'b0;
                     src_in   = AW'({in_byte[7:4], low_ff});
                     cnt_in   = CNT_W'(in_byte[3:0]) + MIN_MATCH;
                     state_in = ST_READ;
                  end
                  default: begin
                     flags_in = {FLAG_FILL, in_byte};
                     phase_in = PH_FIRST;
                  end
               endcase
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               ram_we     = 1'b1;
               emit.valid = 1'b1;
               emit.data  = emit_data;
               emit.last  = last;
               emit.done  = (prod_inc == out_len);
               wpos_in    = wpos_ff + AW'(1);
               prod_in    = prod_inc;
               if (last) begin
                  flags_in = flags_next;
                  phase_in = flags_next[8] ? PH_FIRST : PH_FLAG;
                  state_in = ST_IDLE;
               end else begin
                  src_in   = src_ff + AW'(1);
                  cnt_in   = cnt_ff - CNT_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/lzsd_top.sv
`timescale 1ns / 1ps

// lzss_stream_decoder: LZSS decompressor with a 4 KiB history window.
//
// req_* carries compressed bytes, one per beat. rsp_* returns decompressed
// bytes; rsp_tlast marks the final byte caused by a request beat and
// rsp_tuser marks the byte that reaches the programmed output length.
// csr_* writes the 24-bit output length; it is always ready.
//
// Request bytes are taken only in ST_IDLE. A flag byte or the first byte of a
// reference is absorbed there; a literal then passes ST_EMIT, and a reference
// copies 3 to 18 bytes, each a registered read in ST_READ followed by a
// write-back in ST_EMIT on the same window RAM, which sets the pace.
// Each response beat is formed in ST_EMIT and held in the response register.
//
// After reset every window entry is cleared to zero, one entry a cycle;
// req_tready stays low meanwhile. A stalled receiver holds the response
// register; decoding then waits with req_tready low.
module lzss_stream_decoder #(
   parameter int WINDOW_SIZE = lzsd_pkg::WINDOW_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] in_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] out_byte
   output logic                        rsp_tlast,
   output logic                        rsp_tuser,   // [0] stream_done
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lzsd_pkg::LEN_W-1:0]  csr_wdata
);

   import lzsd_pkg::*;

   logic [LEN_W-1:0]  len_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff;
   logic              rsp_last_ff, rsp_done_ff;
   logic              out_free;
   emit_type          emit;

   lzsd_seq #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .out_len  (len_ff),
      .out_free (out_free),
      .emit     (emit)
   );

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_data_ff <= emit.data;
         rsp_last_ff <= emit.last;
         rsp_done_ff <= emit.done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free)
      else $error("response overwritten while stalled");

   a_idle_no_emit: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !emit.valid)
      else $error("emit while accepting requests");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("stream_done without run_last");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("ready during window clear");

endmodule

### verif/tb_lzss_stream_decoder.sv
`timescale 1ns / 1ps

module tb_lzss_stream_decoder;
   import lzsd_pkg::*;

   localparam logic [LEN_W-1:0] LEN_MAX     = 24'hffffff;
   localparam int               CYCLE_LIMIT = 500000;
   localparam int               SETTLE_CYC  = 64;
   localparam int               LONG_HOLD   = 400;

   localparam logic [7:0] DIR_SEQ [22] = '{
      8'hff, 8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80, 8'h7f, 8'hfe,
      8'hf0, 8'hee, 8'hff, 8'hff, 8'hf0, 8'h00, 8'h0f, 8'h00, 8'h87,
      8'h33, 8'hcc, 8'h00, 8'hff
   };

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       done;
   } out_beat_type;

   class lzss_scoreboard;
      logic [7:0]       hist [WINDOW_SIZE_DEF];
      logic [POS_W-1:0] wpos;
      logic [15:0]      ctrl_bits;
      phase_type        rx_phase;
      logic [7:0]       ref_lo;
      logic [LEN_W-1:0] out_count;
      logic [LEN_W-1:0] out_limit;
      out_beat_type     pending [$];
      int               errors;

      function new();
         foreach (hist[i]) hist[i] = '0;
         wpos      = START_POS;
         ctrl_bits = '0;
         rx_phase  = PH_FLAG;
         ref_lo    = '0;
         out_count = '0;
         out_limit = '0;
         errors    = 0;
      endfunction

      function void set_limit(logic [LEN_W-1:0] v);
         out_limit = v;
      endfunction

      function void put_out(logic [7:0] b);
         out_beat_type e;
         hist[wpos] = b;
         wpos       = wpos + 12'd1;
         out_count  = out_count + 24'd1;
         e.data     = b;
         e.last     = 1'b0;
         e.done     = (out_count == out_limit);
         pending.push_back(e);
      endfunction

      function void next_ctrl();
         ctrl_bits = ctrl_bits >> 1;
         rx_phase  = ctrl_bits[8] ? PH_FIRST : PH_FLAG;
      endfunction

      // decode one compressed byte, queueing the bytes it yields
      function void note_input(logic [7:0] b);
         int               n0;
         int               cnt;
         int               i;
         logic [POS_W-1:0] pos;
         out_beat_type     e;
         n0 = pending.size();
         if (out_count >= out_limit) return;
         case (rx_phase)
            PH_FIRST: begin
               if (ctrl_bits[0]) begin
                  put_out(b);
                  next_ctrl();
               end else begin
                  ref_lo   = b;
                  rx_phase = PH_SECOND;
               end
            end
            PH_SECOND: begin
               pos = {b[7:4], ref_lo};
               cnt = int'(b[3:0]) + int'(MIN_MATCH);
               for (i = 0; i < cnt && out_count < out_limit; i++) begin
                  put_out(hist[pos + 12'(i)]);
               end
               next_ctrl();
            end
            default: begin
               ctrl_bits = {FLAG_FILL, b};
               rx_phase  = PH_FIRST;
            end
         endcase
         if (pending.size() > n0) begin
            e      = pending.pop_back();
            e.last = 1'b1;
            pending.push_back(e);
         end
      endfunction

      function void check_result(logic [7:0] data, logic last, logic done);
         out_beat_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, actual data %02h last %0b done %0b",
                     $time, data, last, done);
            return;
         end
         e = pending.pop_front();
         if (data !== e.data) begin
            errors++;
            $display("%0t: out_byte expected %02h, actual %02h", $time, e.data, data);
         end
         if (last !== e.last) begin
            errors++;
            $display("%0t: run_last expected %0b, actual %0b", $time, e.last, last);
         end
         if (done !== e.done) begin
            errors++;
            $display("%0t: stream_done expected %0b, actual %0b", $time, e.done, done);
         end
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;
   logic             rsp_tlast;
   logic             rsp_tuser;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_wdata  = '0;

   lzss_scoreboard sb = new();
   int             snd_idle    = 0;
   int             rcv_stall   = 0;
   int             sent_count  = 0;
   int             hold_left   = 0;
   int             cycle_count = 0;
   logic           hold_req    = 1'b0;

   lzss_stream_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
      if (hold_req) begin
         hold_left = LONG_HOLD;
         hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_stall);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(b);
      sent_count++;
   endtask

   task automatic program_length(input logic [LEN_W-1:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_limit(v);
      csr_valid <= 1'b0;
   endtask

   // flag byte followed by its eight controls, half the references near the write pointer
   task automatic send_packet();
      logic [7:0]       flag;
      logic [POS_W-1:0] pos;
      int               k;
      flag = 8'($urandom_range(255));
      send_byte(flag);
      for (k = 0; k < 8; k++) begin
         if (flag[k]) begin
            send_byte(8'($urandom));
         end else begin
            if ($urandom_range(1) == 1) begin
               pos = sb.wpos - 12'($urandom_range(40, 1));
            end else begin
               pos = 12'($urandom);
            end
            send_byte(pos[7:0]);
            send_byte({pos[11:8], 4'($urandom)});
         end
      end
   endtask

   task automatic realign();
      while (sb.rx_phase != PH_FLAG) send_byte(8'($urandom));
   endtask

   task automatic run_random(input int n_items);
      int start;
      start = sent_count;
      while (sent_count - start < n_items) begin
         if ($urandom_range(99) < 85) begin
            send_packet();
         end else begin
            repeat ($urandom_range(5, 1)) send_byte(8'($urandom));
         end
      end
      realign();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      drain();
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      program_length(LEN_MAX);

      foreach (DIR_SEQ[i]) send_byte(DIR_SEQ[i]);

      run_random(14);
      snd_idle = 86;
      run_random(14);
      snd_idle  = 0;
      rcv_stall = 86;
      run_random(14);
      snd_idle  = 21;
      rcv_stall = 21;
      run_random(14);
      snd_idle  = 0;
      rcv_stall = 0;
      settle();

      // reference cut short by the length limit, then ignored input
      program_length(sb.out_count + 24'd7);
      send_byte(8'h00);
      send_byte(8'($urandom));
      send_byte({4'($urandom), 4'hf});
      repeat (4) send_byte(8'($urandom));
      settle();

      program_length('0);
      repeat (3) send_byte(8'($urandom));
      settle();

      // resume mid-stream
      program_length(LEN_MAX);
      realign();
      settle();

      // limit reached on a literal
      program_length(sb.out_count + 24'd2);
      send_byte(8'hff);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h56);
      settle();

      program_length(LEN_MAX);
      realign();

      // receiver holds off while input keeps coming
      hold_req <= 1'b1;
      repeat (2) send_packet();
      drain();
      send_packet();
      settle();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### lzss_stream_decoder.f
hw/rtl/lzsd_pkg.sv
hw/rtl/lzsd_ram.sv
hw/rtl/lzsd_seq.sv
hw/rtl/lzsd_top.sv
verif/tb_lzss_stream_decoder.sv
